### rtl/lzwc_pkg.sv
// Shared types and constants of the LZ77 window copy block.
`default_nettype none
package lzwc_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned DIST_W   = 16;
  localparam int unsigned WSIZE_W  = 16;
  localparam int unsigned S_DATA_W = 32;
  localparam int unsigned M_DATA_W = 8;

  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 16'd32768;

  typedef enum logic [1:0] {
    ERR_OK            = 2'd0,
    ERR_BEFORE_START  = 2'd1,
    ERR_BEYOND_WINDOW = 2'd2,
    ERR_ZERO_DIST     = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_COPY = 2'b10
  } state_e;

  // One byte slot handed from the token sequencer to the write-back stage.
  typedef struct packed {
    logic              valid;
    logic              lit;
    logic              last;
    err_e              err;
    logic [BYTE_W-1:0] lit_byte;
  } issue_t;

endpackage
`default_nettype wire

### rtl/lzwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lzwc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32768
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### rtl/lzwc_issue.sv
// Token sequencer: checks matches, walks copy bytes and issues history reads.
`default_nettype none
module lzwc_issue #(
  parameter int unsigned WINDOW     = 32768,
  parameter int unsigned MAX_LENGTH = 64,
  localparam int unsigned AW        = $clog2(WINDOW)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            tok_valid_i,
  output logic                                 tok_ready_o,
  input  wire logic                            mode_i,
  input  wire logic [lzwc_pkg::BYTE_W-1:0]     literal_byte_i,
  input  wire logic [lzwc_pkg::LEN_W-1:0]      match_length_i,
  input  wire logic [lzwc_pkg::DIST_W-1:0]     match_distance_i,
  input  wire logic [lzwc_pkg::WSIZE_W-1:0]    window_size_i,
  input  wire logic                            slot_free_i,
  output lzwc_pkg::issue_t                     iss_o,
  output logic      [AW-1:0]                   iss_addr_o,
  output logic                                 rd_en_o,
  output logic      [AW-1:0]                   rd_addr_o
);
  import lzwc_pkg::*;

  localparam int unsigned BW  = $clog2(WINDOW + 1);
  localparam int unsigned CW  = ((BW > DIST_W) ? BW : DIST_W) + 1;
  localparam int unsigned LW  = $clog2(MAX_LENGTH + 1);
  localparam logic [CW-1:0] WIN_C   = CW'(WINDOW);
  localparam logic [AW:0]   WIN_S   = (AW + 1)'(WINDOW);
  localparam logic [AW-1:0] PTR_TOP = AW'(WINDOW - 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LENGTH);

  state_e        state_q, state_d;
  logic [AW-1:0] ip_q, ip_d;
  logic [BW-1:0] bp_q, bp_d;
  logic [LW-1:0] rem_q, rem_d;
  logic [AW-1:0] wd_q, wd_d;

  logic          accept;
  logic          step;
  logic [CW-1:0] dist_c, bp_c, ws_c, limit_c;
  err_e          chk_err;
  logic [LW-1:0] len_sat;
  logic [AW:0]   ra_sum;
  logic [AW-1:0] ip_inc;
  logic [BW-1:0] bp_inc;

  assign tok_ready_o = (state_q == ST_IDLE) && slot_free_i;
  assign accept      = tok_valid_i && tok_ready_o;
  assign step        = (state_q == ST_COPY) && slot_free_i;

  assign dist_c  = CW'(match_distance_i);
  assign bp_c    = CW'(bp_q);
  assign ws_c    = CW'(window_size_i);
  assign limit_c = (ws_c < WIN_C) ? ws_c : WIN_C;

  always_comb begin
    if (match_distance_i == '0) begin
      chk_err = ERR_ZERO_DIST;
    end else if ((dist_c > bp_c) && (bp_c < WIN_C)) begin
      chk_err = ERR_BEFORE_START;
    end else if (dist_c > limit_c) begin
      chk_err = ERR_BEYOND_WINDOW;
    end else begin
      chk_err = ERR_OK;
    end
  end

  assign len_sat = (match_length_i > LEN_MAX) ? LW'(MAX_LENGTH) : LW'(match_length_i);

  // Read position is ip - distance, kept in range with one wrap correction.
  assign ra_sum = {1'b0, ip_q} + {1'b0, wd_q};
  assign ip_inc = (ip_q == PTR_TOP) ? '0 : ip_q + AW'(1);
  assign bp_inc = (bp_q == BW'(WINDOW)) ? bp_q : bp_q + BW'(1);

  always_comb begin
    state_d        = state_q;
    ip_d           = ip_q;
    bp_d           = bp_q;
    rem_d          = rem_q;
    wd_d           = wd_q;
    iss_o          = '0;
    iss_o.err      = ERR_OK;
    iss_o.lit_byte = literal_byte_i;
    iss_addr_o     = ip_q;
    rd_en_o        = 1'b0;
    rd_addr_o      = (ra_sum >= WIN_S) ? AW'(ra_sum - WIN_S) : AW'(ra_sum);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!mode_i) begin
            iss_o.valid = 1'b1;
            iss_o.lit   = 1'b1;
            iss_o.last  = 1'b1;
            ip_d        = ip_inc;
            bp_d        = bp_inc;
          end else if (chk_err != ERR_OK) begin
            iss_o.valid = 1'b1;
            iss_o.last  = 1'b1;
            iss_o.err   = chk_err;
          end else if (len_sat != '0) begin
            rem_d   = len_sat;
            wd_d    = AW'(WIN_C - dist_c);
            state_d = ST_COPY;
          end
        end
      end
      ST_COPY: begin
        if (step) begin
          rd_en_o     = 1'b1;
          iss_o.valid = 1'b1;
          iss_o.last  = (rem_q == LW'(1));
          ip_d        = ip_inc;
          bp_d        = bp_inc;
          rem_d       = rem_q - LW'(1);
          if (rem_q == LW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ip_q    <= '0;
      bp_q    <= '0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      ip_q    <= ip_d;
      bp_q    <= bp_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wd_q <= wd_d;
  end

endmodule
`default_nettype wire

### rtl/lz77_window_copy.sv
// Literal issues on accept; match takes a setup step, then one byte/cycle while not stalled.
// A literal or error result passes the write-back and the output register after acceptance;
// copy bytes issue from ST_COPY; the single history RAM port pair sets one byte/cycle.
// Reset clears write pointer, byte count, sequencer and output valids; window_size = 32768.
// History RAM is not cleared: range checks keep reads inside written bytes.
`default_nettype none
module lz77_window_copy #(
  parameter int unsigned WINDOW     = 32768,
  parameter int unsigned MAX_LENGTH = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lzwc_pkg::WSIZE_W-1:0]    cfg_wdata_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // literal_byte [7:0], match_length [14:8], match_distance [30:15], zero [31]
  input  wire logic [lzwc_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // mode [0]
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // out_byte [7:0]
  output logic      [lzwc_pkg::M_DATA_W-1:0]   m_axis_tdata,
  output logic                                 m_axis_tlast,
  // error_code [1:0]
  output logic      [1:0]                      m_axis_tuser
);
  import lzwc_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW);

  logic [WSIZE_W-1:0] wsize_q;

  issue_t        iss;
  logic [AW-1:0] iss_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;

  logic              b_valid_q;
  logic              b_lit_q;
  logic              b_last_q;
  err_e              b_err_q;
  logic [BYTE_W-1:0] b_byte_q;
  logic [AW-1:0]     b_wa_q;
  logic              fwd_q;
  logic [BYTE_W-1:0] wlast_q;

  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_last_q;
  err_e              out_err_q;

  logic              adv;
  logic              slot_free;
  logic              wr_en;
  logic [BYTE_W-1:0] b_data;

  assign adv       = !out_valid_q || m_axis_tready;
  assign slot_free = !b_valid_q || adv;

  lzwc_issue #(
    .WINDOW     (WINDOW),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_issue (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tok_valid_i      (s_axis_tvalid),
    .tok_ready_o      (s_axis_tready),
    .mode_i           (s_axis_tuser),
    .literal_byte_i   (s_axis_tdata[7:0]),
    .match_length_i   (s_axis_tdata[14:8]),
    .match_distance_i (s_axis_tdata[30:15]),
    .window_size_i    (wsize_q),
    .slot_free_i      (slot_free),
    .iss_o            (iss),
    .iss_addr_o       (iss_addr),
    .rd_en_o          (rd_en),
    .rd_addr_o        (rd_addr)
  );

  // Distance one reads the byte written in the same cycle: take it from wlast_q.
  always_comb begin
    if (b_err_q != ERR_OK) begin
      b_data = '0;
    end else if (b_lit_q) begin
      b_data = b_byte_q;
    end else if (fwd_q) begin
      b_data = wlast_q;
    end else begin
      b_data = rd_data;
    end
  end

  assign wr_en = b_valid_q && adv && (b_err_q == ERR_OK);

  lzwc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WINDOW)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (b_wa_q),
    .wdata_i (b_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q     <= WSIZE_RESET;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        wsize_q <= cfg_wdata_i;
      end
      if (iss.valid) begin
        b_valid_q <= 1'b1;
      end else if (adv) begin
        b_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (iss.valid) begin
      b_lit_q  <= iss.lit;
      b_last_q <= iss.last;
      b_err_q  <= iss.err;
      b_byte_q <= iss.lit_byte;
      b_wa_q   <= iss_addr;
      fwd_q    <= rd_en && wr_en && (rd_addr == b_wa_q);
    end
    if (wr_en) begin
      wlast_q <= b_data;
    end
    if (adv) begin
      out_byte_q <= b_data;
      out_last_q <= b_last_q;
      out_err_q  <= b_err_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_err_q;

endmodule
`default_nettype wire
